>>> src/rtcrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcrb_pkg: shared types and constants of the BCD clock register bank
// Bus operation codes, register numbers, store port structs and the
// decimal digit split used for the time readout.
// ----------------------------------------------------------------------------
package rtcrb_pkg;

  typedef enum logic [1:0] {
    OP_INDEX = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int unsigned REGS_PER_BANK = 13;

  localparam logic [3:0] REG_HOUR_SEL = 4'd10;
  localparam logic [3:0] REG_LEAP     = 4'd11;
  localparam logic [3:0] REG_MODE     = 4'hD;
  localparam logic [3:0] REG_NOP      = 4'hE;
  localparam logic [3:0] REG_CLEAR    = 4'hF;

  localparam logic [5:0] PM_OFFSET  = 6'd20;
  localparam logic [5:0] HOURS_HALF = 6'd12;
  localparam logic [7:0] UNREADABLE = 8'hFF;

  // Request from the pipeline into the register store
  typedef struct packed {
    logic       fire;
    op_t        op;
    logic [3:0] nib;
  } store_req_t;

  // State seen by the read path
  typedef struct packed {
    logic [3:0] index;
    logic [1:0] mode;
    logic [3:0] bank_nib;
    logic       hour_24;
  } store_stat_t;

  // Tens digit of a value below 128: multiply by the reciprocal of ten
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [17:0] p;
    p = {11'd0, v} * 18'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t;
    logic [6:0] r;
    t = {3'd0, tens_of(v)} * 7'd10;
    r = v - t;
    return r[3:0];
  endfunction

endpackage

>>> src/rtcrb_time_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcrb_time_digits: time readout decoder
// Splits the current calendar time into the BCD digit of one register,
// with the 12-hour form applied when selected.
// ----------------------------------------------------------------------------
module rtcrb_time_digits
  import rtcrb_pkg::*;
(
  input  logic [3:0] index,
  input  logic       hour_24,
  input  logic [5:0] seconds,
  input  logic [5:0] minutes,
  input  logic [4:0] hours,
  input  logic [2:0] weekday,
  input  logic [4:0] day_of_month,
  input  logic [3:0] month,
  input  logic [6:0] year_offset,
  output logic [3:0] digit
);

  logic [5:0] hour_adj;

  // 12-hour form: afternoon hours read as hour - 12 + 20
  always_comb begin
    hour_adj = {1'b0, hours};
    if (!hour_24 && (hour_adj >= HOURS_HALF)) begin
      hour_adj = hour_adj - HOURS_HALF + PM_OFFSET;
    end
  end

  always_comb begin
    unique case (index)
      4'd0:    digit = ones_of({1'b0, seconds});
      4'd1:    digit = tens_of({1'b0, seconds});
      4'd2:    digit = ones_of({1'b0, minutes});
      4'd3:    digit = tens_of({1'b0, minutes});
      4'd4:    digit = ones_of({1'b0, hour_adj});
      4'd5:    digit = tens_of({1'b0, hour_adj});
      4'd6:    digit = {1'b0, weekday};
      4'd7:    digit = ones_of({2'd0, day_of_month});
      4'd8:    digit = tens_of({2'd0, day_of_month});
      4'd9:    digit = ones_of({3'd0, month});
      4'd10:   digit = tens_of({3'd0, month});
      4'd11:   digit = ones_of(year_offset);
      4'd12:   digit = tens_of(year_offset);
      default: digit = 4'd0;
    endcase
  end

endmodule

>>> src/rtcrb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcrb_store: index, mode and nibble banks
// Holds the register index, the bank mode and the alarm and RAM banks,
// applies index and data writes, and presents the addressed nibble.
// ----------------------------------------------------------------------------
module rtcrb_store
  import rtcrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_req_t  req,
  output store_stat_t stat
);

  logic [3:0] index;
  logic [1:0] mode;
  logic [3:0] bank1 [REGS_PER_BANK];
  logic [3:0] bank2 [REGS_PER_BANK];
  logic [3:0] bank3 [REGS_PER_BANK];

  logic       in_bank;
  logic [3:0] bank_nib;

  assign in_bank = (index < REGS_PER_BANK[3:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= 4'd0;
      mode  <= 2'd0;
      for (int i = 0; i < REGS_PER_BANK; i++) begin
        bank1[i] <= 4'd0;
        bank2[i] <= 4'd0;
        bank3[i] <= 4'd0;
      end
    end else if (req.fire) begin
      if (req.op == OP_INDEX) begin
        index <= req.nib;
      end else if (req.op == OP_WRITE) begin
        if (index == REG_MODE) begin
          mode <= req.nib[1:0];
        end else if (index == REG_CLEAR) begin
          if (req.nib[0]) begin
            for (int i = 0; i < REGS_PER_BANK; i++) begin
              bank1[i] <= 4'd0;
            end
          end
        end else if (in_bank) begin
          // time mode drops the write
          case (mode)
            2'd1:    bank1[index] <= req.nib;
            2'd2:    bank2[index] <= req.nib;
            2'd3:    bank3[index] <= req.nib;
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    bank_nib = 4'd0;
    if (in_bank) begin
      case (mode)
        2'd1:    bank_nib = bank1[index];
        2'd2:    bank_nib = bank2[index];
        2'd3:    bank_nib = bank3[index];
        default: bank_nib = 4'd0;
      endcase
    end
  end

  assign stat.index    = index;
  assign stat.mode     = mode;
  assign stat.bank_nib = bank_nib;
  assign stat.hour_24  = bank1[REG_HOUR_SEL][0];

endmodule

>>> src/bcd_rtc_register_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_rtc_register_bank: BCD clock chip register interface
// A read request passes the input register, then the result register, before
// its byte is presented; it waits in the input register while the result
// register is full. Throughput: one request per cycle while no read waits on
// a full result register, set by the single input stage that decodes and
// applies each request before the next one. Synchronous active-high reset
// clears index, mode, all nibble banks and both pipeline valids.
// ----------------------------------------------------------------------------
module bcd_rtc_register_bank
  import rtcrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] value,
  input  logic [5:0] seconds,
  input  logic [5:0] minutes,
  input  logic [4:0] hours,
  input  logic [2:0] weekday,
  input  logic [4:0] day_of_month,
  input  logic [3:0] month,
  input  logic [6:0] year_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  // Input register: one request waiting to be applied
  logic       s1_valid;
  op_t        s1_op;
  logic [3:0] s1_nib;
  logic [5:0] s1_sec;
  logic [5:0] s1_min;
  logic [4:0] s1_hour;
  logic [2:0] s1_wday;
  logic [4:0] s1_mday;
  logic [3:0] s1_mon;
  logic [6:0] s1_year;

  logic        out_free;
  logic        s1_advance;
  logic        read_fire;
  store_req_t  req;
  store_stat_t stat;
  logic [3:0]  time_digit;
  logic [7:0]  read_data_next;

  // The result register frees when empty or taken this cycle
  assign out_free = !out_valid || out_ready;

  // Writes never wait; a read waits only for the result register
  assign s1_advance = s1_valid && ((s1_op != OP_READ) || out_free);
  assign read_fire  = s1_valid && (s1_op == OP_READ) && out_free;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload: load on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op_t'(operation);
      s1_nib  <= value[3:0];
      s1_sec  <= seconds;
      s1_min  <= minutes;
      s1_hour <= hours;
      s1_wday <= weekday;
      s1_mday <= day_of_month;
      s1_mon  <= month;
      s1_year <= year_offset;
    end
  end

  // Apply the request to the store as it leaves the input register
  assign req.fire = s1_advance;
  assign req.op   = s1_op;
  assign req.nib  = s1_nib;

  rtcrb_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  rtcrb_time_digits u_time (
    .index        (stat.index),
    .hour_24      (stat.hour_24),
    .seconds      (s1_sec),
    .minutes      (s1_min),
    .hours        (s1_hour),
    .weekday      (s1_wday),
    .day_of_month (s1_mday),
    .month        (s1_mon),
    .year_offset  (s1_year),
    .digit        (time_digit)
  );

  // Read decode: time digits in mode 0, bank nibbles otherwise; the leap counter
  // replaces register 11 of the alarm bank; register 13 reads the mode, others 0xFF
  always_comb begin
    if (stat.index < REGS_PER_BANK[3:0]) begin
      if (stat.mode == 2'd0) begin
        read_data_next = {4'd0, time_digit};
      end else if ((stat.mode == 2'd1) && (stat.index == REG_LEAP)) begin
        read_data_next = {6'd0, s1_year[1:0]};
      end else begin
        read_data_next = {4'd0, stat.bank_nib};
      end
    end else if (stat.index == REG_MODE) begin
      read_data_next = {6'd0, stat.mode};
    end else begin
      read_data_next = UNREADABLE;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= read_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      read_data <= read_data_next;
    end
  end

  // An empty input stage always takes a request
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

  // Index and data writes never stall the pipeline
  a_write_no_stall : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_op != OP_READ)) |-> in_ready)
    else $error("write request stalled");

  // A result appears only after a read left the input stage
  a_result_from_read : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && (s1_op == OP_READ)))
    else $error("result without a read request");

  // Reset leaves index and mode at zero
  a_reset_state : assert property (@(posedge clk)
    $past(rst) |-> ((stat.index == 4'd0) && (stat.mode == 2'd0)))
    else $error("index or mode not cleared by reset");

endmodule

>>> dv/bcd_rtc_register_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_rtc_register_bank_tb: self-checking bench for the BCD clock register bank
// Drives index writes, data writes, reads and unused requests with random
// clock readings and random idle on both channels. A scoreboard keeps its own
// copy of index, mode and nibble banks, predicts every read byte and compares
// it with the byte that comes back, in order.
// ----------------------------------------------------------------------------
module bcd_rtc_register_bank_tb;
  import rtcrb_pkg::*;

  localparam logic [1:0] MODE_TIME  = 2'd0;
  localparam logic [1:0] MODE_ALARM = 2'd1;
  localparam int unsigned RANDOM_REQUESTS = 2000;

  // Scoreboard: mirrors the register bank and holds the bytes that pending
  // reads must return, oldest first.
  class rtc_scoreboard;
    logic [3:0] sel_index;
    logic [1:0] bank_mode;
    logic [3:0] nibble_mem[3 * REGS_PER_BANK];
    logic [7:0] read_queue[$];
    int unsigned mismatches;
    int unsigned reads_checked;
    int unsigned bank_writes;
    int unsigned alarm_clears;

    function new();
      sel_index = '0;
      bank_mode = MODE_TIME;
      foreach (nibble_mem[i]) nibble_mem[i] = '0;
      mismatches = 0;
      reads_checked = 0;
      bank_writes = 0;
      alarm_clears = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Byte a read returns for the current index, mode and clock reading
    function logic [7:0] predict_read(logic [5:0] s, logic [5:0] mi, logic [4:0] h,
                                      logic [2:0] wd, logic [4:0] dm, logic [3:0] mo,
                                      logic [6:0] yr);
      int unsigned hr;
      int unsigned digits[13];
      int unsigned slot;
      hr = {27'd0, h};
      slot = 0;
      if (sel_index >= REGS_PER_BANK) begin
        if (sel_index == REG_MODE) return {6'd0, bank_mode};
        return UNREADABLE;
      end
      if (bank_mode == MODE_TIME) begin
        // 12-hour form unless the alarm bank's hour select bit is set
        if (!nibble_mem[REG_HOUR_SEL][0] && hr >= HOURS_HALF) hr = hr - HOURS_HALF + PM_OFFSET;
        // clock digits in register order, ones digit before tens digit
        digits = '{s % 10, s / 10, mi % 10, mi / 10, hr % 10, hr / 10, wd,
                   dm % 10, dm / 10, mo % 10, mo / 10, yr % 10, yr / 10};
        return 8'(digits[sel_index]);
      end
      if (bank_mode == MODE_ALARM && sel_index == REG_LEAP) return {6'd0, yr[1:0]};
      slot = (bank_mode - MODE_ALARM) * REGS_PER_BANK + sel_index;
      return {4'd0, nibble_mem[slot]};
    endfunction

    // Note one accepted request: update the mirror or queue a read byte
    task note_request(op_t op, logic [7:0] val, logic [5:0] s, logic [5:0] mi,
                      logic [4:0] h, logic [2:0] wd, logic [4:0] dm, logic [3:0] mo,
                      logic [6:0] yr);
      logic [3:0] nib;
      int unsigned slot;
      nib = val[3:0];
      case (op)
        OP_INDEX: sel_index = nib;
        OP_WRITE: begin
          if (sel_index == REG_MODE) begin
            bank_mode = nib[1:0];
          end else if (sel_index == REG_CLEAR) begin
            if (nib[0]) begin
              for (int i = 0; i < REGS_PER_BANK; i++) nibble_mem[i] = '0;
              alarm_clears++;
            end
          end else if (sel_index != REG_NOP && bank_mode != MODE_TIME) begin
            slot = (bank_mode - MODE_ALARM) * REGS_PER_BANK + sel_index;
            nibble_mem[slot] = nib;
            bank_writes++;
          end
        end
        OP_READ: read_queue.push_back(predict_read(s, mi, h, wd, dm, mo, yr));
        default: ;
      endcase
    endtask

    // Check one returned byte against the oldest pending read
    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (read_queue.size() == 0) begin
        report_mismatch($sformatf("read byte 0x%02h with no read pending", got));
      end else begin
        want = read_queue.pop_front();
        reads_checked++;
        if (got !== want)
          report_mismatch($sformatf("read_data 0x%02h, predicted 0x%02h", got, want));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  logic [7:0] value;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic [2:0] weekday;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [6:0] year_offset;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;

  rtc_scoreboard sb;
  int unsigned   requests_sent;
  bit            calm;  // no idle on either side while set

  always #5 clk = ~clk;

  bcd_rtc_register_bank dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .value        (value),
    .seconds      (seconds),
    .minutes      (minutes),
    .hours        (hours),
    .weekday      (weekday),
    .day_of_month (day_of_month),
    .month        (month),
    .year_offset  (year_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data)
  );

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Sample both handshakes at the rising edge; inputs only move at the
  // falling edge, so nothing here races the block.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(op_t'(operation), value, seconds, minutes, hours, weekday,
                        day_of_month, month, year_offset);
      if (out_valid && out_ready) sb.check_result(read_data);
    end
  end

  // Read side: hold ready for a random stretch, then stall at random.
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      n = $urandom_range(0, 6);
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // Present one request at a falling edge and hold it until accepted, then
  // leave a random gap. Always returns at a falling edge.
  task automatic send_request(op_t op, logic [7:0] val);
    int unsigned g;
    operation = op;
    value     = val;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Select a register; the upper nibble is don't-care, so randomize it
  task automatic send_index(logic [3:0] rn);
    logic [7:0] v;
    v = 8'($urandom);
    v[3:0] = rn;
    send_request(OP_INDEX, v);
  endtask

  task automatic set_clock(logic [5:0] s, logic [5:0] mi, logic [4:0] h, logic [2:0] wd,
                           logic [4:0] dm, logic [3:0] mo, logic [6:0] yr);
    seconds = s; minutes = mi; hours = h; weekday = wd;
    day_of_month = dm; month = mo; year_offset = yr;
  endtask

  // Advance the clock reading: mostly a valid calendar time, sometimes any
  // bit pattern the ports allow.
  task automatic random_clock();
    if ($urandom_range(0, 4) == 0) begin
      set_clock(6'($urandom), 6'($urandom), 5'($urandom), 3'($urandom),
                5'($urandom), 4'($urandom), 7'($urandom));
    end else begin
      set_clock(6'($urandom_range(0, 60)), 6'($urandom_range(0, 59)),
                5'($urandom_range(0, 23)), 3'($urandom_range(0, 6)),
                5'($urandom_range(1, 31)), 4'($urandom_range(1, 12)),
                7'($urandom_range(0, 99)));
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned next_calm;
    logic [7:0]  v;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_NONE;
    value     = '0;
    calm      = 1'b0;
    requests_sent = 0;
    set_clock(0, 0, 0, 0, 1, 1, 0);
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed requests ----
    // Time mode right after reset, clock at the top of every field range
    set_clock(60, 59, 23, 6, 31, 12, 99);
    send_request(OP_NONE, 8'hFF);          // unused operation: no read byte
    send_request(OP_READ, 8'h00);          // seconds ones digit
    send_index(4);
    send_request(OP_READ, 8'h00);          // hour 23 in 12-hour form
    send_request(OP_WRITE, 8'hA7);         // time mode write, dropped
    send_request(OP_READ, 8'h00);
    set_clock(0, 0, 12, 0, 1, 1, 0);       // noon crosses into PM
    send_index(5);
    send_request(OP_READ, 8'h00);
    // Alarm bank: select 24-hour form, read the leap counter
    send_index(REG_MODE);
    send_request(OP_WRITE, 8'hF1);
    send_request(OP_READ, 8'h00);
    send_index(REG_HOUR_SEL);
    send_request(OP_WRITE, 8'h01);
    send_index(REG_LEAP);
    set_clock(60, 59, 23, 6, 31, 12, 99);
    send_request(OP_WRITE, 8'h05);         // stored, but reads show the leap count
    send_request(OP_READ, 8'h00);
    send_index(REG_MODE);
    send_request(OP_WRITE, 8'h00);
    send_index(4);
    send_request(OP_READ, 8'h00);          // hour 23 now in 24-hour form
    // Write-only registers and the alarm clear
    send_index(REG_NOP);
    send_request(OP_READ, 8'hFF);
    send_index(REG_CLEAR);
    send_request(OP_WRITE, 8'hFE);         // bit 0 clear: no effect
    send_request(OP_WRITE, 8'h01);         // clears the alarm bank
    send_request(OP_READ, 8'h00);

    // ---- random requests ----
    next_calm = requests_sent + 150;
    n = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < n) begin
      if (requests_sent >= next_calm) begin
        calm = ($urandom_range(0, 3) == 0);
        next_calm += 150;
      end
      kind = $urandom_range(0, 99);
      random_clock();
      if (kind < 45) begin
        // Pick a register and work on it in the current mode
        send_index($urandom_range(0, 9) < 8 ? 4'($urandom_range(0, REGS_PER_BANK - 1))
                                            : 4'($urandom_range(0, 15)));
        repeat ($urandom_range(1, 4)) begin
          random_clock();
          send_request($urandom_range(0, 9) < 6 ? OP_READ : OP_WRITE, 8'($urandom));
        end
      end else if (kind < 60) begin
        send_index(REG_MODE);
        send_request(OP_WRITE, 8'($urandom));
        if ($urandom_range(0, 1)) send_request(OP_READ, 8'($urandom));
      end else if (kind < 68) begin
        send_index(REG_CLEAR);
        send_request(OP_WRITE, 8'($urandom));
      end else if (kind < 76) begin
        // Flip between 12- and 24-hour readout
        send_index(REG_MODE);
        v = 8'($urandom);
        v[1:0] = MODE_ALARM;
        send_request(OP_WRITE, v);
        send_index(REG_HOUR_SEL);
        send_request(OP_WRITE, 8'($urandom));
      end else if (kind < 86) begin
        // Sweep the clock digits in time mode
        send_index(REG_MODE);
        v = 8'($urandom);
        v[1:0] = MODE_TIME;
        send_request(OP_WRITE, v);
        for (int rn = 0; rn < REGS_PER_BANK; rn++) begin
          random_clock();
          send_index(4'(rn));
          send_request(OP_READ, 8'($urandom));
        end
      end else if (kind < 94) begin
        send_index(4'($urandom_range(0, 15)));
        send_request(OP_READ, 8'($urandom));
      end else begin
        // Noise: unused operation or a stray access to whatever is selected
        send_request(op_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    // ---- drain ----
    in_valid = 1'b0;
    calm = 1'b0;
    while (sb.read_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests, %0d reads checked, %0d bank writes, %0d alarm clears.",
             requests_sent, sb.reads_checked, sb.bank_writes, sb.alarm_clears);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("bcd_rtc_register_bank verification clean");
    end else begin
      $display("bcd_rtc_register_bank verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Timeout with %0d reads still pending", sb.read_queue.size());
    $display("bcd_rtc_register_bank verification failed");
    $finish;
  end

endmodule

>>> filelist.f
src/rtcrb_pkg.sv
src/rtcrb_time_digits.sv
src/rtcrb_store.sv
src/bcd_rtc_register_bank.sv
dv/bcd_rtc_register_bank_tb.sv
